// ===== rtl/core/jeo_pkg.sv =====
// shared types and constants for the josephus elimination order block
// no dependencies
package jeo_pkg;

  localparam int MAX_PEOPLE = 64;
  localparam int POS_W      = $clog2(MAX_PEOPLE);
  localparam int CNT_W      = $clog2(MAX_PEOPLE + 1);
  localparam int PERSON_W   = 7;
  localparam int COUNT_W    = 7;
  localparam int STEP_W     = 16;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 16;
  localparam int IN_DW      = 8;
  localparam int OUT_DW     = 8;

  typedef enum logic [CFG_AW-1:0] {
    REG_COUNT = 2'd0,
    REG_START = 2'd1,
    REG_STEP  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CFG  = 2'd1,
    ST_FINISHED = 2'd2
  } status_t;

  typedef struct packed {
    logic               init;
    logic               wipe;
    logic               adv;
    logic               kill;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   start;
  } circ_cmd_t;

endpackage

// ===== rtl/core/jeo_mod.sv =====
// iterative restoring remainder unit, one numerator bit per cycle
// depends on jeo_pkg
module jeo_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [jeo_pkg::STEP_W-1:0] num,
  input  logic [jeo_pkg::CNT_W-1:0]  den,
  output logic                      done,
  output logic [jeo_pkg::CNT_W-1:0]  rem
);
  import jeo_pkg::*;

  localparam int ITER_W = $clog2(STEP_W);

  logic                busy_r;
  logic                done_r;
  logic [ITER_W-1:0]   cnt_r;
  logic [STEP_W-1:0]   num_r;
  logic [CNT_W-1:0]    den_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    rem_nxt;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;

  always_comb begin
    trial = {rem_r, num_r[STEP_W-1]};
    diff  = trial - {1'b0, den_r};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = diff[CNT_W-1:0];
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        num_r  <= {num_r[STEP_W-2:0], 1'b0};
        cnt_r  <= cnt_r + 1'b1;
        busy_r <= (cnt_r != ITER_W'(STEP_W - 1));
        done_r <= (cnt_r == ITER_W'(STEP_W - 1));
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/jeo_circle.sv =====
// alive map of the circle kept as a ring rotated to the scanning position
// depends on jeo_pkg
module jeo_circle (
  input  logic                      clk,
  input  logic                      rst_n,
  input  jeo_pkg::circ_cmd_t        cmd,
  output logic [jeo_pkg::POS_W-1:0] pos,
  output logic                      next_alive
);
  import jeo_pkg::*;

  // ring_r[0] is the seat at pos_r, ring_r[1] the seat after it
  logic [MAX_PEOPLE-1:0] ring_r;
  logic [MAX_PEOPLE-1:0] ring_nxt;
  logic [MAX_PEOPLE-1:0] init_map;
  logic [POS_W-1:0]      seat;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_inc;

  always_comb begin
    seat = '0;
    for (int i = 0; i < MAX_PEOPLE; i++) begin
      seat        = cmd.start + POS_W'(i);
      init_map[i] = ({1'b0, seat} < cmd.count);
    end
  end

  always_comb begin
    ring_nxt = ring_r;
    if (cmd.kill) begin
      ring_nxt[0] = 1'b0;
    end
    if (cmd.adv) begin
      ring_nxt = {ring_nxt[0], ring_nxt[MAX_PEOPLE-1:1]};
    end
  end

  assign pos_inc = pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r <= '0;
      pos_r  <= '0;
    end else if (cmd.wipe) begin
      ring_r <= '0;
      pos_r  <= '0;
    end else if (cmd.init) begin
      ring_r <= init_map;
      pos_r  <= cmd.start;
    end else begin
      ring_r <= ring_nxt;
      if (cmd.adv) begin
        pos_r <= pos_inc;
      end
    end
  end

  assign pos        = pos_r;
  assign next_alive = ring_r[1];

endmodule

// ===== rtl/core/josephus_elimination_order_top.sv =====
// josephus elimination order: top level with sequencer and config registers
// depends on jeo_pkg, jeo_mod, jeo_circle
//
// usage
//   in channel: one item per request, in_tdata[0] = restart. restart loads
//   the circle from the config registers and yields the first removed
//   person; a plain request yields the next one. one result per item.
//   out channel: out_tdata = person, out_tlast = final survivor,
//   out_tuser = status (ok, invalid config, sequence finished).
//   config: cfg_we writes register cfg_addr (count, start, step); values are
//   sampled only at restart.
//   a removal runs the bit-serial remainder unit, then the pointer walks
//   the 64-seat alive map one seat per cycle, up to 63 seats to the victim
//   and at least 1, up to 63, more to the next living person.
//   in_tready is high only while the sequencer is idle; one item at a time.
//   the output register holds a finished result while the receiver stalls,
//   and the next item may already be accepted meanwhile.
//   reset clears the circle; a request before any restart reports the
//   sequence as finished. config registers reset to 1.
module josephus_elimination_order_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [jeo_pkg::IN_DW-1:0]   in_tdata,   // [0] restart
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [jeo_pkg::OUT_DW-1:0]  out_tdata,  // [6:0] person
  output logic                        out_tlast,  // last
  output logic [1:0]                  out_tuser,  // [1:0] status
  input  logic                        cfg_we,
  input  logic [jeo_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [jeo_pkg::CFG_DW-1:0]  cfg_wdata
);
  import jeo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_DIV,
    S_WALK,
    S_FIND,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [COUNT_W-1:0]  count_r;
  logic [COUNT_W-1:0]  start_r;
  logic [STEP_W-1:0]   step_r;
  logic [STEP_W-1:0]   step_latch_r;
  logic [CNT_W-1:0]    remaining_r;
  logic [POS_W-1:0]    k_r;
  logic [PERSON_W-1:0] res_person_r;
  logic                res_last_r;
  status_t             res_status_r;
  logic                out_tvalid_r;
  logic [PERSON_W-1:0] out_person_r;
  logic                out_last_r;
  status_t             out_status_r;

  circ_cmd_t           cmd;
  logic [POS_W-1:0]    pos;
  logic                next_alive;
  logic                mod_start;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;
  logic                accept;
  logic                restart;
  logic                cfg_ok;

  assign accept  = in_tvalid && in_tready;
  assign restart = in_tdata[0];
  assign cfg_ok  = (count_r != '0) && (32'(count_r) <= MAX_PEOPLE) &&
                   (start_r != '0) && (start_r <= count_r) && (step_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(1);
      start_r <= COUNT_W'(1);
      step_r  <= STEP_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        REG_START: start_r <= cfg_wdata[COUNT_W-1:0];
        REG_STEP:  step_r  <= cfg_wdata[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.count = count_r;
    cmd.start = POS_W'(start_r - 1'b1);
    mod_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && restart) begin
          cmd.wipe = !cfg_ok;
          cmd.init = cfg_ok;
        end
      end
      S_TAKE: begin
        cmd.kill  = (remaining_r == CNT_W'(1));
        mod_start = (remaining_r > CNT_W'(1));
      end
      S_WALK: begin
        cmd.kill = (k_r == '0);
        cmd.adv  = (k_r != '0);
      end
      S_FIND: cmd.adv = 1'b1;
      default: ;
    endcase
  end

  jeo_circle u_circle (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .pos        (pos),
    .next_alive (next_alive)
  );

  jeo_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (step_latch_r - 1'b1),
    .den   (remaining_r),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      remaining_r  <= '0;
      step_latch_r <= STEP_W'(1);
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_EMIT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (restart && !cfg_ok) begin
              remaining_r  <= '0;
              res_person_r <= '0;
              res_last_r   <= 1'b0;
              res_status_r <= ST_BAD_CFG;
              state_r      <= S_EMIT;
            end else begin
              if (restart) begin
                remaining_r  <= CNT_W'(count_r);
                step_latch_r <= step_r;
              end
              state_r <= S_TAKE;
            end
          end
        end
        S_TAKE: begin
          if (remaining_r == '0) begin
            res_person_r <= '0;
            res_last_r   <= 1'b0;
            res_status_r <= ST_FINISHED;
            state_r      <= S_EMIT;
          end else if (remaining_r == CNT_W'(1)) begin
            remaining_r  <= '0;
            res_person_r <= PERSON_W'(pos) + 1'b1;
            res_last_r   <= 1'b1;
            res_status_r <= ST_OK;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (mod_done) begin
            k_r     <= mod_rem[POS_W-1:0];
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (k_r == '0) begin
            remaining_r  <= remaining_r - 1'b1;
            res_person_r <= PERSON_W'(pos) + 1'b1;
            res_last_r   <= 1'b0;
            res_status_r <= ST_OK;
            state_r      <= S_FIND;
          end else if (next_alive) begin
            k_r <= k_r - 1'b1;
          end
        end
        S_FIND: begin
          if (next_alive) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_person_r <= res_person_r;
            out_last_r   <= res_last_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DW'(out_person_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/core/jeo_checker.sv =====
// port-level checks for the josephus elimination order top level
// depends on jeo_pkg; bound to josephus_elimination_order_top
module jeo_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [jeo_pkg::OUT_DW-1:0]  out_tdata,
  input logic                        out_tlast,
  input logic [1:0]                  out_tuser
);
  import jeo_pkg::*;

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // error results carry no person and no last flag
  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == '0 && !out_tlast))
    else $error("error result with nonzero payload");

  // ok results name a real person
  a_ok_person: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_OK) |->
      (out_tdata != '0 && 32'(out_tdata) <= MAX_PEOPLE))
    else $error("ok result with person out of range");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      ($stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("output payload changed while stalled");

endmodule

bind josephus_elimination_order_top jeo_checker u_jeo_checker (.*);
